### src/linear_probe_hash_table_defines.svh
// ----------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Shared check macros, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define LPHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht: same-cycle check failed");

// next-cycle implication
`define LPHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht: next-cycle check failed");

`endif

### src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Sizes, codes, slot layout and helpers shared by the table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int DATA_WIDTH  = 32;
  localparam int KEY_W       = 31;
  localparam int CNT_W       = 11;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SZ_W        = $clog2(TABLE_DEPTH + 1);
  localparam int BIT_W       = $clog2(KEY_W);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SLOT   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_LIVE    = 2'd1,
    TAG_DELETED = 2'd2
  } tag_t;

  typedef enum logic [0:0] {
    CFG_TABLE_SIZE = 1'b0,
    CFG_ITEM_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    tag_t                  tag;
    logic [KEY_W-1:0]      key;
    logic [DATA_WIDTH-1:0] data;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [SZ_W-1:0] active_size(input logic [CNT_W-1:0] ts);
    logic [SZ_W-1:0] r;
    if (ts == '0) begin
      r = SZ_W'(1);
    end else if (32'(ts) > TABLE_DEPTH) begin
      r = SZ_W'(TABLE_DEPTH);
    end else begin
      r = SZ_W'(ts);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/lpht_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/lpht_mod.sv
// ----------------------------------------------------------------------------
// Home slot modulo unit
// Restoring remainder of key by table size, one key bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_mod (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [lpht_pkg::KEY_W-1:0] dividend,
  input  wire logic [lpht_pkg::SZ_W-1:0]  divisor,
  output lpht_pkg::mod_rsp_t            rsp
);

  import lpht_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [BIT_W-1:0] bit_r;
  logic [KEY_W-1:0] q_r;
  logic [SZ_W-1:0]  rem_r;
  logic [SZ_W-1:0]  div_r;
  logic [SZ_W:0]    trial;
  logic [SZ_W-1:0]  rem_nxt;

  always_comb begin
    trial = {rem_r, q_r[KEY_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = SZ_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = SZ_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start) begin
      bit_r <= BIT_W'(KEY_W - 1);
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      bit_r <= bit_r - BIT_W'(1);
      q_r   <= q_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = ADDR_W'(rem_r);

endmodule

`default_nettype wire

### src/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// Linear probe hash table
// Steps: home slot modulo (one key bit a cycle), then a slot read and a check
//   of the slot RAM per probed slot, then the output register, which waits
//   while the last result is not yet taken; an unused command goes straight
//   to the output register. One item at a time: in_ready is low from an
//   accepted item until its result is registered. Reset: a clearing pass
//   marks all TABLE_DEPTH slots empty, one a cycle, with in_ready low meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_command,
  input  wire logic [lpht_pkg::KEY_W-1:0]        in_key,
  input  wire logic [lpht_pkg::DATA_WIDTH-1:0]   in_payload,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_status,
  output logic [lpht_pkg::DATA_WIDTH-1:0]        out_found_data,
  output logic [lpht_pkg::CNT_W-1:0]             out_live_count,
  output logic                                   out_at_limit,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [lpht_pkg::CNT_W-1:0]        cfg_wdata
);

  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_MOD,
    S_RD,
    S_CHK,
    S_FIN
  } state_t;

  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_r, clr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      table_size_r, table_size_nxt;
  logic [CNT_W-1:0]      item_limit_r, item_limit_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [1:0]            cmd_r, cmd_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [SZ_W-1:0]       size_r, size_nxt;
  logic [ADDR_W-1:0]     pos_r, pos_nxt;
  logic [SZ_W-1:0]       n_r, n_nxt;
  logic [DATA_WIDTH-1:0] found_r, found_nxt;
  status_t               status_r, status_nxt;

  status_t               out_status_r, out_status_nxt;
  logic [DATA_WIDTH-1:0] out_found_r, out_found_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;
  logic                  out_limit_r, out_limit_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  slot_t                 wr_slot;
  logic [SLOT_W-1:0]     ram_rdata;
  slot_t                 rd_slot;

  logic                  mod_start;
  mod_rsp_t              mod_rsp;

  logic [SZ_W-1:0]       pos_inc;
  logic [ADDR_W-1:0]     pos_wrap;
  logic                  lap_end;
  logic                  advance;

  lpht_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_slot),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  lpht_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_key),
    .divisor  (active_size(table_size_r)),
    .rsp      (mod_rsp)
  );

  assign rd_slot  = ram_rdata;
  assign pos_inc  = SZ_W'(pos_r) + SZ_W'(1);
  assign pos_wrap = (pos_inc == size_r) ? '0 : ADDR_W'(pos_inc);
  assign lap_end  = (n_r + SZ_W'(1)) == size_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    count_nxt      = count_r;
    table_size_nxt = table_size_r;
    item_limit_nxt = item_limit_r;
    out_valid_nxt  = out_valid_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    data_nxt       = data_r;
    size_nxt       = size_r;
    pos_nxt        = pos_r;
    n_nxt          = n_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    out_limit_nxt  = out_limit_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    wr_slot        = '0;
    mod_start      = 1'b0;
    advance        = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_TABLE_SIZE: table_size_nxt = cfg_wdata;
        CFG_ITEM_LIMIT: item_limit_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_r;
        wr_slot.tag  = TAG_EMPTY;
        clr_nxt      = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          key_nxt    = in_key;
          data_nxt   = in_payload;
          size_nxt   = active_size(table_size_r);
          n_nxt      = '0;
          found_nxt  = '0;
          status_nxt = ST_NOT_FOUND;
          case (in_command)
            CMD_INSERT, CMD_REMOVE, CMD_SEARCH: begin
              mod_start = 1'b1;
              state_nxt = S_MOD;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          pos_nxt   = mod_rsp.rem;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (rd_slot.tag != TAG_LIVE) begin
              ram_we       = 1'b1;
              wr_slot.tag  = TAG_LIVE;
              wr_slot.key  = key_r;
              wr_slot.data = data_r;
              count_nxt    = count_r + CNT_W'(1);
              status_nxt   = ST_DONE;
              state_nxt    = S_FIN;
            end else begin
              advance = 1'b1;
            end
          end
          CMD_REMOVE, CMD_SEARCH: begin
            if (rd_slot.tag == TAG_EMPTY) begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_FIN;
            end else if (rd_slot.tag == TAG_LIVE && rd_slot.key == key_r) begin
              if (cmd_r == CMD_REMOVE) begin
                ram_we       = 1'b1;
                wr_slot.tag  = TAG_DELETED;
                wr_slot.key  = rd_slot.key;
                wr_slot.data = rd_slot.data;
                if (count_r != '0) begin
                  count_nxt = count_r - CNT_W'(1);
                end
              end else begin
                found_nxt = rd_slot.data;
              end
              status_nxt = ST_DONE;
              state_nxt  = S_FIN;
            end else begin
              advance = 1'b1;
            end
          end
          default: state_nxt = S_FIN;
        endcase
        if (advance) begin
          if (lap_end) begin
            status_nxt = (cmd_r == CMD_INSERT) ? ST_NO_SLOT : ST_NOT_FOUND;
            state_nxt  = S_FIN;
          end else begin
            pos_nxt   = pos_wrap;
            n_nxt     = n_r + SZ_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = found_r;
          out_count_nxt  = count_r;
          out_limit_nxt  = (count_r == item_limit_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      count_r      <= '0;
      table_size_r <= CNT_W'(1024);
      item_limit_r <= CNT_W'(1024);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      count_r      <= count_nxt;
      table_size_r <= table_size_nxt;
      item_limit_r <= item_limit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    data_r       <= data_nxt;
    size_r       <= size_nxt;
    pos_r        <= pos_nxt;
    n_r          <= n_nxt;
    found_r      <= found_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    out_limit_r  <= out_limit_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_data = out_found_r;
  assign out_live_count = out_count_r;
  assign out_at_limit   = out_limit_r;

  `LPHT_ASSERT_IMP(a_count_max, 1'b1, 32'(count_r) <= TABLE_DEPTH)
  `LPHT_ASSERT_IMP(a_pos_range, state_r == S_CHK, SZ_W'(pos_r) < size_r)
  `LPHT_ASSERT_IMP(a_mod_done, mod_rsp.done, state_r == S_MOD)
  `LPHT_ASSERT_IMP(a_quiet_ram, state_r == S_IDLE || state_r == S_FIN, !ram_we)
  `LPHT_ASSERT_NXT(a_count_hold, state_r != S_CHK, $stable(count_r))

endmodule

`default_nettype wire

### test/lpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table checker
// Watches the command, result and register channels, keeps its own copy of
// the slot table and registers, and compares every result field by field.
// ----------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [DATA_WIDTH-1:0] in_payload,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            out_status,
  input  logic [DATA_WIDTH-1:0] out_found_data,
  input  logic [CNT_W-1:0]      out_live_count,
  input  logic                  out_at_limit,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [CNT_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    pending_count,
  output int                    live_entries,
  output int                    results_checked,
  output int                    no_slot_seen
);

  typedef struct packed {
    status_t               status;
    logic [DATA_WIDTH-1:0] found_data;
    logic [CNT_W-1:0]      live_count;
    logic                  at_limit;
  } table_result_t;

  tag_t                  slot_state   [TABLE_DEPTH];
  logic [KEY_W-1:0]      slot_keys    [TABLE_DEPTH];
  logic [DATA_WIDTH-1:0] slot_payload [TABLE_DEPTH];
  logic [CNT_W-1:0]      live_total;
  logic [CNT_W-1:0]      size_reg;
  logic [CNT_W-1:0]      limit_reg;
  table_result_t         awaited_results[$];
  int                    mismatches = 0;
  int                    checked = 0;
  int                    no_slot = 0;

  function automatic int unsigned probe_span();
    if (size_reg == '0) return 1;
    if (int'(size_reg) > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(size_reg);
  endfunction

  function automatic int locate_key(input logic [KEY_W-1:0] k, input int unsigned span);
    int unsigned pos;
    int unsigned n;
    pos = k % span;
    for (n = 0; n < span; n++) begin
      if (slot_state[pos] == TAG_EMPTY) return -1;
      if (slot_state[pos] == TAG_LIVE && slot_keys[pos] == k) return int'(pos);
      pos = (pos + 1 == span) ? 0 : pos + 1;
    end
    return -1;
  endfunction

  function automatic table_result_t run_command(input logic [1:0] cmd,
                                                input logic [KEY_W-1:0] k,
                                                input logic [DATA_WIDTH-1:0] d);
    table_result_t r;
    int unsigned   span;
    int unsigned   pos;
    int unsigned   n;
    int            hit;
    logic          placed;
    span = probe_span();
    r.status = ST_NOT_FOUND;
    r.found_data = '0;
    case (cmd)
      CMD_INSERT: begin
        r.status = ST_NO_SLOT;
        pos = k % span;
        placed = 1'b0;
        for (n = 0; n < span && !placed; n++) begin
          if (slot_state[pos] != TAG_LIVE) begin
            slot_state[pos] = TAG_LIVE;
            slot_keys[pos] = k;
            slot_payload[pos] = d;
            live_total = live_total + 1'b1;
            r.status = ST_DONE;
            placed = 1'b1;
          end else begin
            pos = (pos + 1 == span) ? 0 : pos + 1;
          end
        end
      end
      CMD_REMOVE: begin
        hit = locate_key(k, span);
        if (hit >= 0) begin
          slot_state[hit] = TAG_DELETED;
          if (live_total != '0) live_total = live_total - 1'b1;
          r.status = ST_DONE;
        end
      end
      CMD_SEARCH: begin
        hit = locate_key(k, span);
        if (hit >= 0) begin
          r.found_data = slot_payload[hit];
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.live_count = live_total;
    r.at_limit = (live_total == limit_reg);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_result_t want;
    if (!rst_n) begin
      foreach (slot_state[i]) slot_state[i] = TAG_EMPTY;
      live_total = '0;
      size_reg = CNT_W'(TABLE_DEPTH);
      limit_reg = CNT_W'(TABLE_DEPTH);
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TABLE_SIZE) begin
          size_reg = cfg_wdata;
        end else begin
          limit_reg = cfg_wdata;
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(run_command(in_command, in_key, in_payload));
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d, found_data %0h", out_status, out_found_data);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (want.status == ST_NO_SLOT) no_slot++;
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_found_data !== want.found_data) begin
            $error("found_data: expected %0h, got %0h", want.found_data, out_found_data);
            mismatches++;
          end
          if (out_live_count !== want.live_count) begin
            $error("live_count: expected %0d, got %0d", want.live_count, out_live_count);
            mismatches++;
          end
          if (out_at_limit !== want.at_limit) begin
            $error("at_limit: expected %0d, got %0d", want.at_limit, out_at_limit);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending_count <= awaited_results.size();
    live_entries <= int'(live_total);
    results_checked <= checked;
    no_slot_seen <= no_slot;
  end

endmodule

### test/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives insert, remove, search and unused commands through directed corner
// cases and random phases over many table sizes and limits, with bursty input
// and a stalling result sink; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'b11;
  localparam int         CYCLE_LIMIT  = 2_000_000;
  localparam int         PHASES       = 12;
  localparam int         PHASE_ITEMS  = 146;
  localparam int         POOL_DEPTH   = 24;

  int unsigned phase_sizes [PHASES] = '{2, 7, 16, 1024, 5, 2047, 1, 12, 64, 3, 9, 1000};

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_command = CMD_INSERT;
  logic [KEY_W-1:0]      in_key = '0;
  logic [DATA_WIDTH-1:0] in_payload = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_status;
  logic [DATA_WIDTH-1:0] out_found_data;
  logic [CNT_W-1:0]      out_live_count;
  logic                  out_at_limit;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index = CFG_TABLE_SIZE;
  logic [CNT_W-1:0]      cfg_wdata = '0;

  int fail_count;
  int pending_count;
  int live_entries;
  int results_checked;
  int no_slot_seen;

  int               cycle_count = 0;
  int               burst_left = 0;
  int               sent_items = 0;
  int               settings_used = 0;
  int               sink_hold = 0;
  logic             sink_open = 1'b0;
  logic [KEY_W-1:0] key_pool[$];

  linear_probe_hash_table DUT (.*);

  lpht_checker table_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (sink_hold == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          sink_open = 1'b1;
          sink_hold = $urandom_range(20, 60);
        end
        1: begin
          sink_open = 1'b0;
          sink_hold = $urandom_range(1, 12);
        end
        default: begin
          sink_open = 1'($urandom_range(0, 1));
          sink_hold = $urandom_range(1, 3);
        end
      endcase
    end
    sink_hold--;
    out_ready <= sink_open;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [KEY_W-1:0] k,
                           input logic [DATA_WIDTH-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key <= k;
    in_payload <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic set_table(input int unsigned size, input int unsigned limit);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TABLE_SIZE;
    cfg_wdata <= CNT_W'(size);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_ITEM_LIMIT;
    cfg_wdata <= CNT_W'(limit);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_item();
    int                    pick;
    logic [1:0]            cmd;
    logic [KEY_W-1:0]      k;
    logic [DATA_WIDTH-1:0] d;
    pick = $urandom_range(0, 99);
    d = $urandom;
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else begin
      k = KEY_W'($urandom);
    end
    if (pick < 45) begin
      cmd = CMD_INSERT;
      if ($urandom_range(0, 4) >= 2) begin
        k = KEY_W'($urandom);
        key_pool.push_back(k);
        if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end
    end else if (pick < 70) begin
      cmd = CMD_REMOVE;
    end else if (pick < 97) begin
      cmd = CMD_SEARCH;
    end else begin
      cmd = CMD_UNUSED;
    end
    send_item(cmd, k, d);
  endtask

  initial begin
    int unsigned limit;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 31'd1, 32'h0000_0000);
    send_item(CMD_INSERT, 31'd0, 32'hA5A5_A5A5);
    send_item(CMD_SEARCH, 31'h7FFF_FFFF, 32'h1234_5678);
    send_item(CMD_SEARCH, 31'd0, 32'h0);
    send_item(CMD_SEARCH, 31'd1025, 32'h0);
    send_item(CMD_REMOVE, 31'd1, 32'h0);
    send_item(CMD_SEARCH, 31'd1025, 32'h0);
    send_item(CMD_REMOVE, 31'd1, 32'h0);
    send_item(CMD_UNUSED, 31'd5, 32'hDEAD_BEEF);
    send_item(CMD_INSERT, 31'd2047, 32'h5A5A_5A5A);
    send_item(CMD_SEARCH, 31'd2047, 32'h0);

    set_table(0, 0);
    send_item(CMD_INSERT, 31'd9, 32'h0000_0009);
    send_item(CMD_REMOVE, 31'd0, 32'h0);
    send_item(CMD_SEARCH, 31'd0, 32'h0);
    send_item(CMD_INSERT, 31'd9, 32'h0000_0009);

    set_table(4, live_entries + 1);
    send_item(CMD_INSERT, 31'd6, 32'h6666_6666);
    send_item(CMD_INSERT, 31'd3, 32'h3333_3333);
    send_item(CMD_INSERT, 31'd4, 32'h4444_4444);
    send_item(CMD_REMOVE, 31'd6, 32'h0);
    send_item(CMD_SEARCH, 31'd10, 32'h0);
    send_item(CMD_SEARCH, 31'd3, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 3) begin
        limit = TABLE_DEPTH;
      end else if (p == 5) begin
        limit = 0;
      end else begin
        limit = live_entries + $urandom_range(0, 4);
      end
      set_table(phase_sizes[p], limit);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_item();
        if (i == PHASE_ITEMS / 2 && p % 4 == 1) drain();
      end
    end

    drain();
    repeat (80) @(posedge clk);
    $display("Run covered %0d commands under %0d table settings, sizes 0 to 2047.",
             sent_items, settings_used);
    $display("Checked %0d results, %0d of them inserts into a full probe lap.",
             results_checked, no_slot_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
